@@ design/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// lse_pkg
// Shared constants and types for the load, sort and emit block: store depth,
// derived widths, sequencer states, the memory request bundle and result flags.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  // Capacity of the element store and the widths that follow from it.
  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAP,
    ST_INNER,
    ST_WB,
    ST_EMIT
  } state_t;

  // One cycle's access to the element store.
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // Result strobe and its flags, registered in the sequencer.
  typedef struct packed {
    logic valid;
    logic last;
    logic overflow;
  } res_flags_t;

endpackage

`default_nettype wire

@@ design/load_sort_emit.sv @@
// ----------------------------------------------------------------------------
// load_sort_emit
// Collects signed 32-bit values into a store, sorts the set in ascending
// order with an in-place exchange sort, and emits it as a run of results.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   input     start / busy       in_value, in_end_of_set
//   result    out_valid strobe   out_sorted_value, out_last, out_overflow
//
// Loading writes each accepted beat to the next entry, if free. A beat marked
// end of set starts the sort, or the emit for a set of one entry: each outer
// position takes a fetch step, a compare step per later entry and a write-back
// step, all paced by the single store read port. The run then leaves at one
// result per cycle. Reset is synchronous and clears the sequencer, count
// and drop flag; the store itself holds no reset value. Results cannot be
// stalled, and busy stays high from the end beat until the last read.
// ----------------------------------------------------------------------------
`default_nettype none

module load_sort_emit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_value,
  input  wire logic               in_end_of_set,
  output logic                    out_valid,
  output logic signed [31:0]      out_sorted_value,
  output logic                    out_last,
  output logic                    out_overflow
);

  import lse_pkg::*;

  mem_req_t          mem_req;
  res_flags_t        res;
  logic [DW-1:0]     rdata;

  // Sequencer.
  lse_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_value      (in_value),
    .in_end_of_set (in_end_of_set),
    .rdata         ($signed(rdata)),
    .busy          (busy),
    .mem_req       (mem_req),
    .res           (res)
  );

  // Element store.
  lse_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // Result beat: registered read data with the flags registered alongside.
  assign out_valid        = res.valid;
  assign out_last         = res.last;
  assign out_overflow     = res.overflow;
  assign out_sorted_value = $signed(rdata);

  // A result only follows a cycle in which the block was busy.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // The run ends on its last beat.
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result beat straight after the last of a run");

  // An end-of-set beat always starts the sort or emit.
  a_end_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_end_of_set) |=> busy)
    else $error("end of set accepted but block did not go busy");

  // Consecutive beats of one run are in ascending order.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && !$past(out_last)) |->
      ($signed($past(out_sorted_value)) <= $signed(out_sorted_value)))
    else $error("sorted run out of order");

endmodule

`default_nettype wire

@@ design/lse_ram.sv @@
// ----------------------------------------------------------------------------
// lse_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. A read of the address written in the same cycle returns the
// old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/lse_ctrl.sv @@
// ----------------------------------------------------------------------------
// lse_ctrl
// Sequencer for the load, sort and emit block. Writes incoming beats into
// the element store, runs the exchange sort as read-compare-write passes over
// the store, then reads the sorted entries out as result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [31:0]       in_value,
  input  wire logic                     in_end_of_set,
  input  wire logic signed [31:0]       rdata,
  output logic                          busy,
  output lse_pkg::mem_req_t             mem_req,
  output lse_pkg::res_flags_t           res
);

  import lse_pkg::*;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     x_r, x_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  res_flags_t        res_r, res_nxt;

  logic              accept;
  logic              full;
  logic [CW-1:0]     set_size;
  logic [CW-1:0]     last_idx;
  logic              x_at_end;
  logic              i_at_end;
  logic              k_at_end;
  logic              swap;

  // Shared conditions.
  assign accept   = start && (state_r == ST_IDLE);
  assign full     = (count_r >= CW'(DEPTH));
  assign set_size = full ? CW'(DEPTH) : CW'(count_r + 1'b1);
  assign last_idx = CW'(count_r - 1'b1);
  assign x_at_end = (CW'(x_r) == last_idx);
  assign i_at_end = (CW'(CW'(i_r) + 2'd2) >= count_r);
  assign k_at_end = (CW'(k_r) == last_idx);
  assign swap     = (cur_r > rdata);
  assign busy     = (state_r != ST_IDLE);
  assign res      = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_end_of_set) begin
          state_nxt = (set_size == CW'(1)) ? ST_EMIT : ST_CAP;
        end
      end
      ST_CAP:   state_nxt = ST_INNER;
      ST_INNER: begin
        if (x_at_end) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB:    state_nxt = i_at_end ? ST_EMIT : ST_CAP;
      ST_EMIT: begin
        if (k_at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Store accesses and datapath register updates.
  always_comb begin
    mem_req   = '0;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    x_nxt     = x_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    res_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        // Load a beat into the next free entry, or note it as dropped.
        if (accept) begin
          if (!full) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count_r[AW-1:0];
            mem_req.wdata = in_value;
          end
          count_nxt = set_size;
          drop_nxt  = drop_r | full;
          i_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_CAP: begin
        // Entry i arrives; start the scan at the entry after it.
        cur_nxt       = rdata;
        mem_req.raddr = AW'(i_r + 1'b1);
        x_nxt         = AW'(i_r + 1'b1);
      end
      ST_INNER: begin
        // Swap a smaller later entry into the held position.
        if (swap) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = x_r;
          mem_req.wdata = cur_r;
          cur_nxt       = rdata;
        end
        if (!x_at_end) begin
          mem_req.raddr = AW'(x_r + 1'b1);
          x_nxt         = AW'(x_r + 1'b1);
        end
      end
      ST_WB: begin
        // Settle entry i and fetch the next outer position.
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = cur_r;
        mem_req.raddr = AW'(i_r + 1'b1);
        i_nxt         = AW'(i_r + 1'b1);
      end
      ST_EMIT: begin
        // Read out one sorted entry per cycle; flags follow the read data.
        mem_req.raddr    = k_r;
        res_nxt.valid    = 1'b1;
        res_nxt.last     = k_at_end;
        res_nxt.overflow = drop_r;
        k_nxt            = AW'(k_r + 1'b1);
        if (k_at_end) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      drop_r  <= 1'b0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      res_r   <= res_nxt;
    end
  end

  // Indices and the held element.
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    x_r   <= x_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire
